// ----- hdl/dds_pkg.sv -----
// Package for the decimal digit stego codec: codes, queue word and digit helpers.
`default_nettype none
package dds_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [1:0] HEADER_PIXELS = 2'd3;

  typedef enum logic [2:0] {
    ST_ENCODED = 3'd0,
    ST_HDR_OK  = 3'd1,
    ST_CHAR    = 3'd2,
    ST_END     = 3'd3,
    ST_NO_MSG  = 3'd4,
    ST_IDLE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_READ   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic        carry;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  chr;
    logic [3:0]  red_rem;
    logic [3:0]  green_rem;
    logic [3:0]  blue_rem;
  } dds_word_t;

  // v / 10 for v < 256: multiply by 205, shift by 11
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return p[15:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [7:0] q10;
    logic [7:0] r;
    q10 = {3'd0, div10(v)} * 8'd10;
    r = v - q10;
    return r[3:0];
  endfunction

  // v / 100 for v < 256: multiply by 41, shift by 12
  function automatic logic [1:0] div100(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd41;
    return p[13:12];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/dds_if.sv -----
// Handshake interfaces: pixel in, result out, mode write.
`default_nettype none
interface dds_pix_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       char_valid;
  logic [7:0] msg_char;

  modport source (output valid, frame_start, red_in, green_in, blue_in, char_valid, msg_char,
                  input ready);
  modport sink (input valid, frame_start, red_in, green_in, blue_in, char_valid, msg_char,
                output ready);
endinterface

interface dds_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] text_char;
  logic [2:0] status;

  modport source (output valid, red_out, green_out, blue_out, text_char, status,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, text_char, status,
                output ready);
endinterface

interface dds_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/dds_front.sv -----
// Front end: takes pixels, tracks header count and decode phase, classifies each word.
`default_nettype none
module dds_front
  import dds_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  dds_pix_if.sink    pix,
  input  wire logic  mode,
  input  wire logic  full,
  output logic       push,
  output dds_word_t  word
);

  logic [1:0] header_count, header_count_next;
  phase_t     decode_phase, decode_phase_next;

  logic [1:0] hc;
  phase_t     ph;
  logic       in_header;
  logic       zero;
  logic [3:0] r_rem, g_rem, b_rem;

  assign pix.ready = !full;
  assign push      = pix.valid && !full;

  always_comb begin
    hc = pix.frame_start ? 2'd0 : header_count;
    ph = pix.frame_start ? PH_HEADER : decode_phase;
    in_header = hc < HEADER_PIXELS;
    r_rem = mod10(pix.red_in);
    g_rem = mod10(pix.green_in);
    b_rem = mod10(pix.blue_in);
    zero = (r_rem == 4'd0) && (g_rem == 4'd0) && (b_rem == 4'd0);

    decode_phase_next = ph;
    word.status = ST_IDLE;
    if (!mode) begin
      word.status = ST_ENCODED;
    end else begin
      case (ph)
        PH_HEADER, PH_READ: begin
          if (in_header) begin
            if (zero) begin
              word.status = ST_HDR_OK;
            end else begin
              word.status = ST_NO_MSG;
              decode_phase_next = PH_DONE;
            end
          end else if (zero) begin
            word.status = ST_END;
            decode_phase_next = PH_DONE;
          end else begin
            word.status = ST_CHAR;
            decode_phase_next = PH_READ;
          end
        end
        default: word.status = ST_IDLE;
      endcase
    end
    header_count_next = in_header ? hc + 2'd1 : hc;

    word.carry     = !mode && !in_header && pix.char_valid;
    word.red       = pix.red_in;
    word.green     = pix.green_in;
    word.blue      = pix.blue_in;
    word.chr       = pix.msg_char;
    word.red_rem   = r_rem;
    word.green_rem = g_rem;
    word.blue_rem  = b_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 2'd0;
      decode_phase <= PH_HEADER;
    end else if (push) begin
      header_count <= header_count_next;
      decode_phase <= decode_phase_next;
    end
  end

  a_no_msg_done: assert property (@(posedge clk) disable iff (rst)
    (push && word.status == ST_NO_MSG) |=> decode_phase == PH_DONE)
    else $error("no message did not close the frame");

endmodule
`default_nettype wire

// ----- hdl/dds_queue.sv -----
// Short word queue between front and back.
`default_nettype none
module dds_queue
  import dds_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire dds_word_t  word_in,
  output logic            full,
  input  wire logic       pop,
  output dds_word_t       word_out,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dds_word_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign word_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count overrun");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hdl/dds_back.sv -----
// Back end: digit replacement or character assembly into the output register.
`default_nettype none
module dds_back
  import dds_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dds_word_t  word,
  input  wire logic       empty,
  output logic            pop,
  dds_res_if.source       res
);

  logic       out_valid;
  logic [3:0] d_r, d_g, d_b;
  logic [8:0] enc_r, enc_g, enc_b;
  logic [9:0] text_sum;

  assign pop       = !empty && (!out_valid || res.ready);
  assign res.valid = out_valid;

  always_comb begin
    d_r = word.carry ? {2'd0, div100(word.chr)} : 4'd0;
    d_g = word.carry ? mod10({3'd0, div10(word.chr)}) : 4'd0;
    d_b = word.carry ? mod10(word.chr) : 4'd0;
    enc_r = {1'b0, word.red}   - {5'd0, word.red_rem}   + {5'd0, d_r};
    enc_g = {1'b0, word.green} - {5'd0, word.green_rem} + {5'd0, d_g};
    enc_b = {1'b0, word.blue}  - {5'd0, word.blue_rem}  + {5'd0, d_b};
    text_sum = {6'd0, word.red_rem} * 10'd100 + {6'd0, word.green_rem} * 10'd10
             + {6'd0, word.blue_rem};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.status <= word.status;
      if (word.status == ST_ENCODED) begin
        res.red_out   <= enc_r[7:0];
        res.green_out <= enc_g[7:0];
        res.blue_out  <= enc_b[7:0];
      end else begin
        res.red_out   <= word.red;
        res.green_out <= word.green;
        res.blue_out  <= word.blue;
      end
      res.text_char <= (word.status == ST_CHAR) ? text_sum[7:0] : 8'd0;
    end
  end

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped word not presented");

endmodule
`default_nettype wire

// ----- hdl/decimal_digit_stego_codec.sv -----
// Top level of the decimal digit stego codec.
`default_nettype none
// Takes one RGB pixel per clock in raster order and returns one result word per
// pixel, in order. Mode 0 rewrites the last decimal digit of each channel to hide
// a character (zero digits in the three header pixels); mode 1 checks the header
// and reads characters back until an all-zero digit triple. Sustained rate is one
// pixel per clock while the result port is ready, set by the front classifier and
// back digit unit; a taken pixel passes through the queue and the output register,
// and a queue of QUEUE_DEPTH words absorbs output stalls before ready deasserts.
// The user must write the mode register only while no pixel is in flight; the block does not enforce this.
module decimal_digit_stego_codec
  import dds_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  dds_pix_if.sink   pix,
  dds_res_if.source res,
  dds_cfg_if.sink   cfg
);

  logic      mode;
  logic      push, pop, full, empty;
  dds_word_t front_word, back_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg.valid) begin
      mode <= cfg.data;
    end
  end

  dds_front u_front (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix),
    .mode (mode),
    .full (full),
    .push (push),
    .word (front_word)
  );

  dds_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .word_in  (front_word),
    .full     (full),
    .pop      (pop),
    .word_out (back_word),
    .empty    (empty)
  );

  dds_back u_back (
    .clk   (clk),
    .rst   (rst),
    .word  (back_word),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

endmodule
`default_nettype wire
